// File: rtl/crcrs_pkg.sv
`timescale 1ns / 1ps

package crcrs_pkg;

    localparam int unsigned MAX_SLOTS = 64;
    localparam int unsigned SLOT_W    = 6;
    localparam int unsigned POS_W     = 5;
    localparam int unsigned OUT_W     = 64;

    localparam logic [7:0] CRC_POLY     = 8'h07;
    localparam logic [7:0] MAGIC_0      = 8'h43;
    localparam logic [7:0] MAGIC_1      = 8'h4B;
    localparam logic [7:0] VERSION_1    = 8'h01;
    localparam logic [7:0] TAG_PATTERN  = 8'hA0;
    localparam logic [7:0] TAG_MASK     = 8'hF8;
    localparam logic [7:0] VALID_MARK   = 8'hA5;
    localparam logic [7:0] HOUR_LIMIT   = 8'd24;
    localparam logic [7:0] MINSEC_LIMIT = 8'd60;

    // byte positions inside a record
    localparam logic [POS_W-1:0] POS_MAGIC_0 = 5'd0;
    localparam logic [POS_W-1:0] POS_MAGIC_1 = 5'd1;
    localparam logic [POS_W-1:0] POS_VERSION = 5'd2;
    localparam logic [POS_W-1:0] POS_TAG     = 5'd3;
    localparam logic [POS_W-1:0] POS_SEQ_LO  = 5'd4;
    localparam logic [POS_W-1:0] POS_SEQ_HI  = 5'd5;
    localparam logic [POS_W-1:0] POS_HOUR    = 5'd6;
    localparam logic [POS_W-1:0] POS_MINUTE  = 5'd7;
    localparam logic [POS_W-1:0] POS_SECOND  = 5'd8;
    localparam logic [POS_W-1:0] POS_A0_HOUR = 5'd9;
    localparam logic [POS_W-1:0] POS_A0_MIN  = 5'd10;
    localparam logic [POS_W-1:0] POS_A0_MEL  = 5'd11;
    localparam logic [POS_W-1:0] POS_A1_HOUR = 5'd12;
    localparam logic [POS_W-1:0] POS_A1_MIN  = 5'd13;
    localparam logic [POS_W-1:0] POS_A1_MEL  = 5'd14;
    localparam logic [POS_W-1:0] POS_A2_HOUR = 5'd15;
    localparam logic [POS_W-1:0] POS_A2_MIN  = 5'd16;
    localparam logic [POS_W-1:0] POS_A2_MEL  = 5'd17;
    localparam logic [POS_W-1:0] POS_CRC     = 5'd18;
    localparam logic [POS_W-1:0] POS_MARK    = 5'd19;

    localparam logic [15:0] SERIAL_HALF = 16'h8000;

    // one CRC-8 byte update, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/crc8_record_scanner_newest_core.sv
`timescale 1ns / 1ps

// Channel   | Ports                          | Contents
// ----------+--------------------------------+----------------------------------------
// byte in   | s_tvalid s_tready s_tdata/user | tdata: record_byte; tuser: scan_start
// result    | m_tvalid m_tready m_tdata      | one transaction after byte 19 of a record
// config    | cfg_wr_en cfg_wr_data          | melody_count, reset value 8
//
// One byte per cycle unless byte 19 waits on a stalled result register: each
// byte is captured in the input register, then checked, folded into the
// bytewise CRC and scored combinationally on its way to the result register.
// Reset clears the record position, CRC, checks and newest-record tracking.
// A stalled result register holds only the byte stage behind it; bytes that
// produce no result still advance past a full result register.

module crc8_record_scanner_newest_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] record_byte
    input  logic        s_tuser,     // [0] scan_start
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] record_valid, [16:1] record_sequence, [21:17] clock_hour,
    // [27:22] clock_minute, [33:28] clock_second, [36:34] alarm_enable_mask,
    // [37] is_newest, [43:38] best_slot, [59:44] top_sequence,
    // [60] any_found, [63:61] zero
    output logic [crcrs_pkg::OUT_W-1:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    localparam int unsigned SW = crcrs_pkg::SLOT_W;
    localparam int unsigned PW = crcrs_pkg::POS_W;

    // configuration
    logic [7:0] melody_count_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    // record and scan state
    logic [PW-1:0] byte_position_reg, byte_position_next;
    logic [7:0]    running_crc_reg,   running_crc_next;
    logic          record_ok_reg,     record_ok_next;
    logic [7:0]    seq_lo_reg,        seq_lo_next;
    logic [7:0]    seq_hi_reg,        seq_hi_next;
    logic [7:0]    tag_byte_reg,      tag_byte_next;
    logic [4:0]    held_hour_reg,     held_hour_next;
    logic [5:0]    held_minute_reg,   held_minute_next;
    logic [5:0]    held_second_reg,   held_second_next;
    logic [SW-1:0] slot_index_reg,    slot_index_next;
    logic [SW-1:0] newest_slot_reg,   newest_slot_next;
    logic [15:0]   newest_seq_reg,    newest_seq_next;
    logic          found_reg,         found_next;

    // result register
    logic                         out_valid_reg;
    logic [crcrs_pkg::OUT_W-1:0]  out_data_reg, out_data_next;

    logic          fire;
    logic          emit;
    logic [PW-1:0] pos;
    logic          first;
    logic [7:0]    crc_base;
    logic          ok_base;
    logic [SW-1:0] slot_eff;
    logic [SW-1:0] newest_slot_eff;
    logic [15:0]   newest_seq_eff;
    logic          found_eff;
    logic          pass;
    logic [7:0]    crc_upd;
    logic [15:0]   seq;
    logic [15:0]   diff;
    logic          newer;
    logic [2:0]    enable_mask;

    // advance the byte stage unless it carries a result that cannot be loaded
    assign fire     = in_valid_reg && (!emit || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            melody_count_reg <= 8'd8;
        end
        else if (cfg_wr_en)
        begin
            melody_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    // scan start restarts the record and clears the newest-record tracking
    always_comb
    begin
        pos             = in_start_reg ? '0 : byte_position_reg;
        if (pos > crcrs_pkg::POS_MARK)
        begin
            pos = '0;
        end
        first           = (pos == crcrs_pkg::POS_MAGIC_0);
        crc_base        = first ? 8'd0 : running_crc_reg;
        ok_base         = first ? 1'b1 : record_ok_reg;
        slot_eff        = in_start_reg ? '0 : slot_index_reg;
        newest_slot_eff = in_start_reg ? '0 : newest_slot_reg;
        newest_seq_eff  = in_start_reg ? '0 : newest_seq_reg;
        found_eff       = in_start_reg ? 1'b0 : found_reg;
    end

    crcrs_byte_check u_check (
        .pos          (pos),
        .data         (in_byte_reg),
        .crc_in       (crc_base),
        .melody_count (melody_count_reg),
        .pass         (pass),
        .crc_out      (crc_upd)
    );

    always_comb
    begin
        emit             = (pos == crcrs_pkg::POS_MARK);
        record_ok_next   = ok_base && pass;
        running_crc_next = crc_upd;
        tag_byte_next    = tag_byte_reg;
        seq_lo_next      = seq_lo_reg;
        seq_hi_next      = seq_hi_reg;
        held_hour_next   = held_hour_reg;
        held_minute_next = held_minute_reg;
        held_second_next = held_second_reg;
        case (pos)
            crcrs_pkg::POS_TAG:    tag_byte_next    = in_byte_reg;
            crcrs_pkg::POS_SEQ_LO: seq_lo_next      = in_byte_reg;
            crcrs_pkg::POS_SEQ_HI: seq_hi_next      = in_byte_reg;
            crcrs_pkg::POS_HOUR:   held_hour_next   = in_byte_reg[4:0];
            crcrs_pkg::POS_MINUTE: held_minute_next = in_byte_reg[5:0];
            crcrs_pkg::POS_SECOND: held_second_next = in_byte_reg[5:0];
            default:               ;
        endcase

        // serial-number compare against the newest so far
        seq   = {seq_hi_reg, seq_lo_reg};
        diff  = seq - newest_seq_eff;
        newer = record_ok_next &&
                (!found_eff || ((diff != 16'd0) && (diff < crcrs_pkg::SERIAL_HALF)));

        newest_slot_next = newest_slot_eff;
        newest_seq_next  = newest_seq_eff;
        found_next       = found_eff;
        slot_index_next  = slot_eff;
        byte_position_next = pos + 1'b1;
        if (emit)
        begin
            byte_position_next = '0;
            if (newer)
            begin
                newest_slot_next = slot_eff;
                newest_seq_next  = seq;
                found_next       = 1'b1;
            end
            slot_index_next = (slot_eff == SW'(crcrs_pkg::MAX_SLOTS - 1)) ? '0
                                                                        : slot_eff + 1'b1;
        end

        enable_mask = (tag_byte_reg == 8'd0) ? 3'd7 : tag_byte_reg[2:0];

        out_data_next = {3'b000,
                         found_next,
                         newest_seq_next,
                         newest_slot_next,
                         newer,
                         enable_mask,
                         record_ok_next ? held_second_reg : 6'd0,
                         record_ok_next ? held_minute_reg : 6'd0,
                         record_ok_next ? held_hour_reg   : 5'd0,
                         seq,
                         record_ok_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            running_crc_reg   <= '0;
            record_ok_reg     <= 1'b1;
            seq_lo_reg        <= '0;
            seq_hi_reg        <= '0;
            tag_byte_reg      <= '0;
            held_hour_reg     <= '0;
            held_minute_reg   <= '0;
            held_second_reg   <= '0;
            slot_index_reg    <= '0;
            newest_slot_reg   <= '0;
            newest_seq_reg    <= '0;
            found_reg         <= 1'b0;
        end
        else if (fire)
        begin
            byte_position_reg <= byte_position_next;
            running_crc_reg   <= running_crc_next;
            record_ok_reg     <= record_ok_next;
            seq_lo_reg        <= seq_lo_next;
            seq_hi_reg        <= seq_hi_next;
            tag_byte_reg      <= tag_byte_next;
            held_hour_reg     <= held_hour_next;
            held_minute_reg   <= held_minute_next;
            held_second_reg   <= held_second_next;
            slot_index_reg    <= slot_index_next;
            newest_slot_reg   <= newest_slot_next;
            newest_seq_reg    <= newest_seq_next;
            found_reg         <= found_next;
        end
    end

    // load a result on byte 19; drop it once the transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // checks
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_position_reg <= crcrs_pkg::POS_MARK)
        else $error("record position out of range");

    a_invalid_zero_time: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[33:17] == 17'd0))
        else $error("time fields reported for invalid record");

    a_newest_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[37]) |->
            (m_tdata[0] && m_tdata[60] && (m_tdata[59:44] == m_tdata[16:1])))
        else $error("newest record does not match reported sequence");

    a_none_found_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !found_reg |-> ((newest_slot_reg == '0) && (newest_seq_reg == 16'd0)))
        else $error("newest tracking set without a valid record");

    a_result_needs_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !emit) |=> (byte_position_reg != '0) || $past(in_start_reg))
        else $error("record position reset without a result");

endmodule

// File: rtl/crcrs_byte_check.sv
`timescale 1ns / 1ps

module crcrs_byte_check (
    input  logic [crcrs_pkg::POS_W-1:0] pos,
    input  logic [7:0]                  data,
    input  logic [7:0]                  crc_in,
    input  logic [7:0]                  melody_count,
    output logic                        pass,
    output logic [7:0]                  crc_out
);

    always_comb
    begin
        case (pos)
            crcrs_pkg::POS_MAGIC_0: pass = (data == crcrs_pkg::MAGIC_0);
            crcrs_pkg::POS_MAGIC_1: pass = (data == crcrs_pkg::MAGIC_1);
            crcrs_pkg::POS_VERSION: pass = (data == crcrs_pkg::VERSION_1);
            crcrs_pkg::POS_TAG:
                pass = (data == 8'd0) ||
                       ((data & crcrs_pkg::TAG_MASK) == crcrs_pkg::TAG_PATTERN);
            crcrs_pkg::POS_HOUR,
            crcrs_pkg::POS_A0_HOUR,
            crcrs_pkg::POS_A1_HOUR,
            crcrs_pkg::POS_A2_HOUR: pass = (data < crcrs_pkg::HOUR_LIMIT);
            crcrs_pkg::POS_MINUTE,
            crcrs_pkg::POS_SECOND,
            crcrs_pkg::POS_A0_MIN,
            crcrs_pkg::POS_A1_MIN,
            crcrs_pkg::POS_A2_MIN:  pass = (data < crcrs_pkg::MINSEC_LIMIT);
            crcrs_pkg::POS_A0_MEL,
            crcrs_pkg::POS_A1_MEL,
            crcrs_pkg::POS_A2_MEL:  pass = (data < melody_count);
            crcrs_pkg::POS_CRC:     pass = (data == crc_in);
            crcrs_pkg::POS_MARK:    pass = (data == crcrs_pkg::VALID_MARK);
            default:                pass = 1'b1;
        endcase
    end

    // fold only the covered bytes; hold the CRC across the check bytes
    assign crc_out = (pos < crcrs_pkg::POS_CRC) ? crcrs_pkg::crc8_byte(crc_in, data) : crc_in;

endmodule
